>>> hdl/bdsc_pkg.sv
// bdsc_pkg: shared types, constants and calendar functions for the business day span counter.
// No dependencies; used by bdsc_ctrl, bdsc_dpath, bdsc_checker and the top level.

package bdsc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int WDAY_W  = 3;
    localparam int MASK_W  = 7;
    localparam int QUO_W   = 8;   // year / 100 for years below 16784
    localparam int REM_W   = 7;   // year % 100
    localparam int WSUM_W  = 15;

    localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;
    localparam logic [12:0]        RECIP_100  = 13'd5243;   // ceil(2^19 / 100)
    localparam int                 RECIP_SHIFT = 19;

    typedef struct packed {
        logic load;
        logic mul_s;
        logic mul_e;
        logic mul_w;
        logic rem;
        logic fold;
        logic check;
        logic step;
        logic emit;
    } bdsc_cmd_t;

    typedef struct packed {
        logic bad;
        logic empty;
        logic at_end;
    } bdsc_status_t;

    function automatic logic leap_year(input logic [1:0] y_lo, input logic [REM_W-1:0] r100,
                                       input logic [1:0] q_lo);
        leap_year = ((y_lo == 2'd0) && (r100 != '0)) || ((r100 == '0) && (q_lo == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_days = 5'd30;
            4'd2:                                       month_days = leap ? 5'd29 : 5'd28;
            default:                                    month_days = 5'd0;
        endcase
    endfunction

    // (31 * mm) / 12 for the March-based month index
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
        case (mm)
            4'd1:    month_term = 5'd2;
            4'd2:    month_term = 5'd5;
            4'd3:    month_term = 5'd7;
            4'd4:    month_term = 5'd10;
            4'd5:    month_term = 5'd12;
            4'd6:    month_term = 5'd15;
            4'd7:    month_term = 5'd18;
            4'd8:    month_term = 5'd20;
            4'd9:    month_term = 5'd23;
            4'd10:   month_term = 5'd25;
            4'd11:   month_term = 5'd28;
            4'd12:   month_term = 5'd31;
            default: month_term = 5'd0;
        endcase
    endfunction

endpackage

>>> hdl/bdsc_ctrl.sv
// bdsc_ctrl: sequencer for setup (weekday, remainders, checks), the day walk and result hand-off.
// Depends on bdsc_pkg.

module bdsc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  bdsc_pkg::bdsc_status_t status,
    output bdsc_pkg::bdsc_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL_S = 9'b000000010,
        ST_MUL_E = 9'b000000100,
        ST_MUL_W = 9'b000001000,
        ST_REM   = 9'b000010000,
        ST_FOLD  = 9'b000100000,
        ST_CHECK = 9'b001000000,
        ST_WALK  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S:
            begin
                cmd.mul_s  = 1'b1;
                state_next = ST_MUL_E;
            end
            ST_MUL_E:
            begin
                cmd.mul_e  = 1'b1;
                state_next = ST_MUL_W;
            end
            ST_MUL_W:
            begin
                cmd.mul_w  = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.bad || status.empty)
                    state_next = ST_DONE;
                else
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.at_end)
                    state_next = ST_DONE;
                else
                    cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/bdsc_dpath.sv
// bdsc_dpath: date registers, shared reciprocal multiplier, weekday fold, validity checks,
// day walker with leap tracking, weekend mask and output word. Depends on bdsc_pkg.

module bdsc_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdsc_pkg::bdsc_cmd_t                 cmd,
    output bdsc_pkg::bdsc_status_t              status,
    input  logic                                cfg_we,
    input  logic [bdsc_pkg::MASK_W-1:0]         cfg_wdata,
    input  logic [bdsc_pkg::YEAR_W-1:0]         start_year,
    input  logic [bdsc_pkg::MONTH_W-1:0]        start_month,
    input  logic [bdsc_pkg::DAY_W-1:0]          start_day,
    input  logic [bdsc_pkg::YEAR_W-1:0]         end_year,
    input  logic [bdsc_pkg::MONTH_W-1:0]        end_month,
    input  logic [bdsc_pkg::DAY_W-1:0]          end_day,
    output logic [bdsc_pkg::COUNT_W-1:0]        business_days,
    output logic                                bad_date
);

    localparam int PROD_W = bdsc_pkg::WSUM_W + 13;

    logic [bdsc_pkg::MASK_W-1:0]   mask_reg;

    logic [bdsc_pkg::YEAR_W-1:0]   sy_reg, ey_reg;
    logic [bdsc_pkg::MONTH_W-1:0]  sm_reg, em_reg;
    logic [bdsc_pkg::DAY_W-1:0]    sd_reg, ed_reg;

    logic [bdsc_pkg::QUO_W-1:0]    qs_reg, qe_reg, qw_reg;
    logic [bdsc_pkg::REM_W-1:0]    rs_reg, re_reg;
    logic [bdsc_pkg::WSUM_W-1:0]   wsum_reg;

    logic [bdsc_pkg::YEAR_W-1:0]   cy_reg;
    logic [bdsc_pkg::MONTH_W-1:0]  cm_reg;
    logic [bdsc_pkg::DAY_W-1:0]    cd_reg;
    logic [bdsc_pkg::REM_W-1:0]    cr_reg;
    logic [1:0]                    cq_reg;
    logic [bdsc_pkg::WDAY_W-1:0]   wd_reg;
    logic [bdsc_pkg::COUNT_W-1:0]  tally_reg;
    logic                          bad_reg;

    logic [bdsc_pkg::COUNT_W-1:0]  out_count_reg;
    logic                          out_bad_reg;

    // weekday setup
    logic                          jan_feb;
    logic [bdsc_pkg::WSUM_W-1:0]   yy;
    logic [bdsc_pkg::MONTH_W-1:0]  mm;
    logic [bdsc_pkg::WSUM_W-1:0]   mul_a;
    logic [PROD_W-1:0]             prod;
    logic [bdsc_pkg::QUO_W-1:0]    quo;
    logic [bdsc_pkg::WSUM_W-1:0]   wsum;
    logic [5:0]                    fold1;
    logic [3:0]                    fold2;
    logic [bdsc_pkg::WDAY_W-1:0]   wd0;

    // checks
    logic [bdsc_pkg::YEAR_W-1:0]   rs_full, re_full;
    logic [bdsc_pkg::DAY_W-1:0]    dim_s, dim_e;
    logic                          ok_s, ok_e;

    // walk
    logic [bdsc_pkg::DAY_W-1:0]    dim_c;
    logic                          month_end, year_end;

    assign jan_feb = (sm_reg <= 4'd2);
    assign yy      = {1'b0, sy_reg} + bdsc_pkg::WSUM_W'(400) - bdsc_pkg::WSUM_W'(jan_feb);
    assign mm      = jan_feb ? sm_reg + 4'd10 : sm_reg - 4'd2;

    always_comb
    begin
        if (cmd.mul_s)
            mul_a = {1'b0, sy_reg};
        else if (cmd.mul_e)
            mul_a = {1'b0, ey_reg};
        else
            mul_a = yy;
    end

    // floor(x / 100) by reciprocal, exact for x below 25600
    assign prod = PROD_W'(mul_a) * PROD_W'(bdsc_pkg::RECIP_100);
    assign quo  = prod[bdsc_pkg::RECIP_SHIFT +: bdsc_pkg::QUO_W];

    assign wsum = bdsc_pkg::WSUM_W'(sd_reg) + yy + (yy >> 2)
                - bdsc_pkg::WSUM_W'(qw_reg) + bdsc_pkg::WSUM_W'(qw_reg >> 2)
                + bdsc_pkg::WSUM_W'(bdsc_pkg::month_term(mm));

    // mod 7 by summing octal digits (8 == 1 mod 7)
    assign fold1 = 6'(wsum_reg[2:0]) + 6'(wsum_reg[5:3]) + 6'(wsum_reg[8:6])
                 + 6'(wsum_reg[11:9]) + 6'(wsum_reg[14:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign wd0   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    assign rs_full = sy_reg - bdsc_pkg::YEAR_W'(qs_reg) * bdsc_pkg::YEAR_W'(100);
    assign re_full = ey_reg - bdsc_pkg::YEAR_W'(qe_reg) * bdsc_pkg::YEAR_W'(100);

    assign dim_s = bdsc_pkg::month_days(sm_reg,
                       bdsc_pkg::leap_year(sy_reg[1:0], rs_reg, qs_reg[1:0]));
    assign dim_e = bdsc_pkg::month_days(em_reg,
                       bdsc_pkg::leap_year(ey_reg[1:0], re_reg, qe_reg[1:0]));
    assign ok_s  = (dim_s != '0) && (sd_reg != '0) && (sd_reg <= dim_s);
    assign ok_e  = (dim_e != '0) && (ed_reg != '0) && (ed_reg <= dim_e);

    assign status.bad    = !(ok_s && ok_e);
    assign status.empty  = !({sy_reg, sm_reg, sd_reg} < {ey_reg, em_reg, ed_reg});
    assign status.at_end = ({cy_reg, cm_reg, cd_reg} == {ey_reg, em_reg, ed_reg});

    assign dim_c     = bdsc_pkg::month_days(cm_reg,
                           bdsc_pkg::leap_year(cy_reg[1:0], cr_reg, cq_reg));
    assign month_end = (cd_reg == dim_c);
    assign year_end  = (cm_reg == 4'd12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= bdsc_pkg::MASK_RESET;
        else if (cfg_we)
            mask_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sy_reg <= start_year;
            sm_reg <= start_month;
            sd_reg <= start_day;
            ey_reg <= end_year;
            em_reg <= end_month;
            ed_reg <= end_day;
        end
        if (cmd.mul_s)
            qs_reg <= quo;
        if (cmd.mul_e)
            qe_reg <= quo;
        if (cmd.mul_w)
            qw_reg <= quo;
        if (cmd.rem)
        begin
            rs_reg   <= rs_full[bdsc_pkg::REM_W-1:0];
            re_reg   <= re_full[bdsc_pkg::REM_W-1:0];
            wsum_reg <= wsum;
        end
        if (cmd.fold)
            wd_reg <= wd0;
        if (cmd.check)
        begin
            cy_reg    <= sy_reg;
            cm_reg    <= sm_reg;
            cd_reg    <= sd_reg;
            cr_reg    <= rs_reg;
            cq_reg    <= qs_reg[1:0];
            tally_reg <= '0;
            bad_reg   <= status.bad;
        end
        else if (cmd.step)
        begin
            if (!mask_reg[wd_reg] && (tally_reg != bdsc_pkg::COUNT_MAX))
                tally_reg <= tally_reg + bdsc_pkg::COUNT_W'(1);
            wd_reg <= (wd_reg == 3'd6) ? 3'd0 : wd_reg + 3'd1;
            if (!month_end)
                cd_reg <= cd_reg + 5'd1;
            else
            begin
                cd_reg <= 5'd1;
                if (!year_end)
                    cm_reg <= cm_reg + 4'd1;
                else
                begin
                    cm_reg <= 4'd1;
                    cy_reg <= cy_reg + bdsc_pkg::YEAR_W'(1);
                    if (cr_reg == 7'd99)
                    begin
                        cr_reg <= '0;
                        cq_reg <= cq_reg + 2'd1;
                    end
                    else
                        cr_reg <= cr_reg + 7'd1;
                end
            end
        end
        if (cmd.emit)
        begin
            out_count_reg <= tally_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign business_days = out_count_reg;
    assign bad_date      = out_bad_reg;

endmodule

>>> hdl/business_day_span_counter_core.sv
// business_day_span_counter_core: top level, counts business days in [start, end).
// Depends on bdsc_pkg, bdsc_ctrl and bdsc_dpath.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   input   | in_valid / in_ready  | start_year, start_month, start_day, end_*
//   output  | out_valid / out_ready| business_days, bad_date
//   config  | cfg_we               | cfg_wdata (weekend mask, bit n = weekday n off)
//
// One word at a time: after the accept come the setup states MUL_S, MUL_E, MUL_W, REM, FOLD
// and CHECK, then the walk at one day of the span per cycle until it reaches the end date,
// then the done state loads the output register and returns to idle for the next word.
// An invalid or empty span skips the walk and goes from the check state to the done state.
// Reset clears control state and sets the mask to Friday and Saturday. A stalled output holds
// its word while the next word is accepted and waits in the done state until the slot frees.

module business_day_span_counter_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdsc_pkg::MASK_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bdsc_pkg::YEAR_W-1:0]   start_year,
    input  logic [bdsc_pkg::MONTH_W-1:0]  start_month,
    input  logic [bdsc_pkg::DAY_W-1:0]    start_day,
    input  logic [bdsc_pkg::YEAR_W-1:0]   end_year,
    input  logic [bdsc_pkg::MONTH_W-1:0]  end_month,
    input  logic [bdsc_pkg::DAY_W-1:0]    end_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bdsc_pkg::COUNT_W-1:0]  business_days,
    output logic                          bad_date
);

    bdsc_pkg::bdsc_cmd_t    cmd;
    bdsc_pkg::bdsc_status_t status;

    bdsc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bdsc_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .business_days (business_days),
        .bad_date      (bad_date)
    );

endmodule

>>> hdl/bdsc_checker.sv
// bdsc_checker: port-level assertions for business_day_span_counter_core, bound to the top.
// Depends on bdsc_pkg.

module bdsc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bdsc_pkg::COUNT_W-1:0]  business_days,
    input logic                          bad_date
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(business_days) && $stable(bad_date))
        else $error("output word changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_date |-> business_days == '0)
        else $error("bad date with nonzero count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accept");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared one cycle after accept");

endmodule

bind business_day_span_counter_core bdsc_checker u_bdsc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .business_days (business_days),
    .bad_date      (bad_date)
);
